// File: sv/tile_tag_cache_lru_unit_macros.svh
// Assertion macros for the tile tag cache.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef TILE_TAG_CACHE_LRU_UNIT_MACROS_SVH
`define TILE_TAG_CACHE_LRU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tile tag cache: check failed");

// Next-cycle implication, disabled while reset is held.
`define TTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tile tag cache: check failed");

`endif

// File: sv/ttc_pkg.sv
// Shared types for the tile tag cache: tag layout, scan link and write command.
// No dependencies.
`timescale 1ns / 1ps

package ttc_pkg;

  localparam int unsigned CoordW = 21;
  localparam int unsigned ZoomW  = 5;
  localparam int unsigned StampW = 32;

  typedef struct packed {
    logic [CoordW-1:0] column;
    logic [CoordW-1:0] row;
    logic [ZoomW-1:0]  zoom;
  } tag_t;

  // Running result that walks from cell to cell during a scan.
  typedef struct packed {
    logic              active;
    logic              found;
    logic [StampW-1:0] best_time;
  } scan_link_t;

  // Write broadcast to all cells; only the addressed cell takes it.
  typedef struct packed {
    logic              en;
    logic              load_tag;
    logic              valid;
    tag_t              tag;
    logic [StampW-1:0] stamp;
  } cell_wr_t;

endpackage

// File: sv/ttc_cell.sv
// One entry of the tile tag cache: tag, valid bit and last-touch stamp,
// plus one stage of the scan chain. Depends on ttc_pkg.
`timescale 1ns / 1ps

module ttc_cell #(
  parameter int unsigned SLOT_W = 6,
  parameter int unsigned INDEX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  lookup,
  input  ttc_pkg::tag_t         key,
  input  ttc_pkg::scan_link_t   link_in,
  input  logic [SLOT_W-1:0]     idx_in,
  output ttc_pkg::scan_link_t   link_out,
  output logic [SLOT_W-1:0]     idx_out,
  input  ttc_pkg::cell_wr_t     wr,
  input  logic [SLOT_W-1:0]     wr_slot
);

  ttc_pkg::tag_t                tag_r;
  logic [ttc_pkg::StampW-1:0]   stamp_r;
  logic                         valid_r;
  ttc_pkg::scan_link_t          link_r;
  ttc_pkg::scan_link_t          link_nxt;
  logic [SLOT_W-1:0]            idx_r;
  logic [SLOT_W-1:0]            idx_nxt;
  logic                         match;
  logic                         older;
  logic                         take;
  logic                         wr_here;

  assign match   = valid_r && (tag_r == key);
  // The first cell always seeds the oldest-entry search.
  assign older   = (INDEX == 0) || (stamp_r < link_in.best_time);
  assign take    = lookup ? (!link_in.found && match) : older;
  assign wr_here = wr.en && (wr_slot == SLOT_W'(INDEX));

  always_comb begin
    link_nxt.active    = link_in.active;
    link_nxt.found     = link_in.found | take;
    link_nxt.best_time = take ? stamp_r : link_in.best_time;
    idx_nxt            = take ? SLOT_W'(INDEX) : idx_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r.active <= 1'b0;
    end else begin
      link_r.active <= link_nxt.active;
    end
    link_r.found     <= link_nxt.found;
    link_r.best_time <= link_nxt.best_time;
    idx_r            <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_here && wr.load_tag) begin
      valid_r <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      stamp_r <= wr.stamp;
      if (wr.load_tag) begin
        tag_r <= wr.tag;
      end
    end
  end

  assign link_out = link_r;
  assign idx_out  = idx_r;

endmodule

// File: sv/tile_tag_cache_lru_unit.sv
// Tile tag cache, top level: request register, control sequencer and the cell chain.
// Depends on ttc_pkg, ttc_cell and tile_tag_cache_lru_unit_macros.svh.
`timescale 1ns / 1ps

// Fully associative tag store for map tiles with least-recently-stamped
// replacement. Each word on the input carries one command: a lookup (in_tuser low)
// or an insert (in_tuser high). Every command returns exactly one result word.
// A lookup, and an insert into a full store, sends a token down the row of
// ENTRIES cells, one cell per clock; an insert into a free slot skips the
// scan and goes straight to ST_FINISH. One command is in flight at a time, and
// in_tready is high only while the unit is idle. The result sits in an output
// register until it is taken; a command that finishes while the previous result
// still waits holds in ST_FINISH until the output register is free.
// Valid bits clear at reset; no clearing pass is needed.
module tile_tag_cache_lru_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tile_x[20:0], tile_y[41:21], zoom_level[46:42], time_ms[78:47], signature_ok[79]
  input  logic [79:0]           in_tdata,
  // command: 0 lookup, 1 insert
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit, slot, stored_valid, evicted, entries_filled, from bit 0 up; zero padded
  output logic [((3 + $clog2(ENTRIES) + $clog2(ENTRIES + 1) + 7) / 8) * 8 - 1:0] out_tdata
);

  localparam int unsigned SLOT_W   = $clog2(ENTRIES);
  localparam int unsigned FILL_W   = $clog2(ENTRIES + 1);
  localparam int unsigned OUT_BITS = 3 + SLOT_W + FILL_W;
  localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                       state_r;
  state_t                       state_nxt;

  logic                         req_cmd_r;
  ttc_pkg::tag_t                req_tag_r;
  logic [ttc_pkg::StampW-1:0]   req_time_r;
  logic                         req_sig_r;
  logic                         req_evict_r;
  logic                         start_r;

  logic [FILL_W-1:0]            filled_r;
  logic [FILL_W-1:0]            filled_nxt;
  logic                         full;

  logic                         scan_found_r;
  logic [SLOT_W-1:0]            scan_idx_r;

  logic                         out_valid_r;
  logic                         res_hit_r;
  logic [SLOT_W-1:0]            res_slot_r;
  logic                         res_stored_r;
  logic                         res_evicted_r;
  logic [FILL_W-1:0]            res_filled_r;

  logic                         in_acc;
  logic                         commit;
  logic                         needs_scan;
  logic                         lookup;

  ttc_pkg::scan_link_t          links [ENTRIES+1];
  logic [SLOT_W-1:0]            idxs  [ENTRIES+1];
  logic [ENTRIES-1:0]           act_vec;

  ttc_pkg::cell_wr_t            wr;
  logic [SLOT_W-1:0]            wr_slot;
  logic                         res_hit;
  logic                         res_stored;
  logic                         res_evicted;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (filled_r == FILL_W'(ENTRIES));
  assign needs_scan = (in_tuser == CMD_LOOKUP) || full;
  assign commit     = (state_r == ST_FINISH) && (!out_valid_r || out_tready);
  assign lookup     = (req_cmd_r == CMD_LOOKUP);

  // Request register.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_cmd_r         <= in_tuser;
      req_tag_r.column  <= in_tdata[20:0];
      req_tag_r.row     <= in_tdata[41:21];
      req_tag_r.zoom    <= in_tdata[46:42];
      req_time_r        <= in_tdata[78:47];
      req_sig_r         <= in_tdata[79];
      req_evict_r       <= (in_tuser == CMD_INSERT) && full;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = needs_scan ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (links[ENTRIES].active) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc && needs_scan;
    end
  end

  // Token enters the first cell in the cycle after acceptance, once the key is registered.
  assign links[0] = '{active: start_r, found: 1'b0, best_time: '1};
  assign idxs[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    ttc_cell #(
      .SLOT_W (SLOT_W),
      .INDEX  (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .lookup   (lookup),
      .key      (req_tag_r),
      .link_in  (links[i]),
      .idx_in   (idxs[i]),
      .link_out (links[i+1]),
      .idx_out  (idxs[i+1]),
      .wr       (wr),
      .wr_slot  (wr_slot)
    );
    assign act_vec[i] = links[i+1].active;
  end

  always_ff @(posedge clk) begin
    if (links[ENTRIES].active) begin
      scan_found_r <= links[ENTRIES].found;
      scan_idx_r   <= idxs[ENTRIES];
    end
  end

  // Result and write-back for the command at hand.
  always_comb begin
    wr.tag      = req_tag_r;
    wr.stamp    = req_time_r;
    wr.valid    = req_sig_r;
    res_hit     = 1'b0;
    res_stored  = 1'b0;
    res_evicted = 1'b0;
    filled_nxt  = filled_r;
    if (lookup) begin
      res_hit     = scan_found_r;
      wr_slot     = scan_found_r ? scan_idx_r : '0;
      wr.en       = commit && scan_found_r;
      wr.load_tag = 1'b0;
    end else begin
      res_stored  = req_sig_r;
      res_evicted = req_evict_r;
      wr.en       = commit;
      wr.load_tag = 1'b1;
      if (req_evict_r) begin
        wr_slot = scan_idx_r;
      end else begin
        wr_slot    = SLOT_W'(filled_r);
        filled_nxt = filled_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        filled_r <= filled_nxt;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res_hit_r     <= res_hit;
      res_slot_r    <= wr_slot;
      res_stored_r  <= res_stored;
      res_evicted_r <= res_evicted;
      res_filled_r  <= filled_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({res_filled_r, res_evicted_r, res_stored_r, res_slot_r,
                              res_hit_r});

  `include "tile_tag_cache_lru_unit_macros.svh"

  `TTC_ASSERT_IMP(a_one_token, 1'b1, $onehot0(act_vec))
  `TTC_ASSERT_IMP(a_token_in_scan, links[ENTRIES].active, state_r == ST_SCAN)
  `TTC_ASSERT_IMP(a_fill_bound, 1'b1, filled_r <= FILL_W'(ENTRIES))
  `TTC_ASSERT_IMP(a_evict_full, commit && !lookup && req_evict_r, full)
  `TTC_ASSERT_NXT(a_commit_shows, commit, out_valid_r && state_r == ST_IDLE)

endmodule
